/* hdl/zmp_pkg.sv */
// ----------------------------------------------------------------------------
// Zipmap parser package
// Shared types, codes and constants for the zipmap stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package zmp_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned LenW    = 32;
	localparam int unsigned LongCntW = 3;

	localparam logic [ByteW-1:0]    LEN_BIG        = 8'd254;
	localparam logic [ByteW-1:0]    MAP_END        = 8'd255;
	localparam logic [LongCntW-1:0] LONG_LEN_BYTES = 3'd4;

	typedef enum logic [3:0] {
		PH_HEADER = 4'd0,
		PH_LEN    = 4'd1,
		PH_LONG   = 4'd2,
		PH_FREE   = 4'd3,
		PH_STR    = 4'd4,
		PH_PAD    = 4'd5,
		PH_END    = 4'd6
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_FRAME = 3'd0,
		ROLE_KEY   = 3'd1,
		ROLE_VALUE = 3'd2,
		ROLE_END   = 3'd3,
		ROLE_ERROR = 3'd4
	} role_t;

	typedef struct packed {
		phase_t                phase;
		logic [LenW-1:0]       bytes_remaining;
		logic [LongCntW-1:0]   long_length_bytes_seen;
		logic [ByteW-1:0]      free_bytes_remaining;
		logic                  reading_value;
	} parser_state_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		role_t            role;
		logic             last_of_string;
		logic             empty_string;
	} tag_t;

	localparam parser_state_t STATE_RESET = '{
		phase:                  PH_HEADER,
		bytes_remaining:        '0,
		long_length_bytes_seen: '0,
		free_bytes_remaining:   '0,
		reading_value:          1'b0
	};

endpackage

`default_nettype wire

/* hdl/zmp_if.sv */
// ----------------------------------------------------------------------------
// Zipmap parser channels
// Valid/ready channels for the incoming blob bytes and the tagged bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface zmp_in_if;
	logic                        valid;
	logic                        ready;
	logic [zmp_pkg::ByteW-1:0]   data_byte;
	logic                        start_of_map;

	modport source (output valid, output data_byte, output start_of_map, input ready);
	modport sink   (input valid, input data_byte, input start_of_map, output ready);
endinterface

interface zmp_out_if;
	logic                        valid;
	logic                        ready;
	logic [zmp_pkg::ByteW-1:0]   out_byte;
	zmp_pkg::role_t              role;
	logic                        last_of_string;
	logic                        empty_string;

	modport source (output valid, output out_byte, output role, output last_of_string,
		output empty_string, input ready);
	modport sink   (input valid, input out_byte, input role, input last_of_string,
		input empty_string, output ready);
endinterface

`default_nettype wire

/* hdl/zmp_step.sv */
// ----------------------------------------------------------------------------
// Zipmap parser step
// Combinational phase update and byte tagging for one blob byte.
// ----------------------------------------------------------------------------
`default_nettype none

module zmp_step (
	input  wire  zmp_pkg::parser_state_t state_i,
	input  wire  [zmp_pkg::ByteW-1:0]    data_byte,
	input  wire                          start_of_map,
	output zmp_pkg::parser_state_t       state_o,
	output zmp_pkg::tag_t                tag
);
	import zmp_pkg::*;

	// Length known: pick what follows it.
	function automatic parser_state_t length_done(input parser_state_t s);
		parser_state_t r;
		r = s;
		if (s.reading_value) begin
			r.phase = PH_FREE;
		end else if (s.bytes_remaining != '0) begin
			r.phase = PH_STR;
		end else begin
			r.reading_value = 1'b1;
			r.phase = PH_LEN;
		end
		return r;
	endfunction

	always_comb begin
		parser_state_t cur;
		parser_state_t nxt;
		role_t         role;
		logic          last;
		logic          empty;
		logic          rv_eff;

		cur = start_of_map ? STATE_RESET : state_i;
		nxt = cur;
		role = ROLE_FRAME;
		last = 1'b0;
		empty = 1'b0;
		rv_eff = 1'b0;

		unique case (cur.phase)
			PH_HEADER: begin
				nxt.reading_value = 1'b0;
				nxt.phase = PH_LEN;
			end
			PH_LONG: begin
				nxt.bytes_remaining[{cur.long_length_bytes_seen[1:0], 3'b000} +: ByteW] =
					cur.bytes_remaining[{cur.long_length_bytes_seen[1:0], 3'b000} +: ByteW]
					| data_byte;
				nxt.long_length_bytes_seen = cur.long_length_bytes_seen + 3'd1;
				if (nxt.long_length_bytes_seen >= LONG_LEN_BYTES) begin
					nxt.long_length_bytes_seen = '0;
					empty = (nxt.bytes_remaining == '0);
					nxt = length_done(nxt);
				end
			end
			PH_FREE: begin
				nxt.free_bytes_remaining = data_byte;
				if (cur.bytes_remaining != '0) begin
					nxt.phase = PH_STR;
				end else if (data_byte != '0) begin
					nxt.phase = PH_PAD;
				end else begin
					nxt.reading_value = 1'b0;
					nxt.phase = PH_LEN;
				end
			end
			PH_STR: begin
				role = cur.reading_value ? ROLE_VALUE : ROLE_KEY;
				if (cur.bytes_remaining != '0) begin
					nxt.bytes_remaining = cur.bytes_remaining - 32'd1;
				end
				if (nxt.bytes_remaining == '0) begin
					last = 1'b1;
					if (!cur.reading_value) begin
						nxt.reading_value = 1'b1;
						nxt.phase = PH_LEN;
					end else if (cur.free_bytes_remaining != '0) begin
						nxt.phase = PH_PAD;
					end else begin
						nxt.reading_value = 1'b0;
						nxt.phase = PH_LEN;
					end
				end
			end
			PH_PAD: begin
				if (cur.free_bytes_remaining != '0) begin
					nxt.free_bytes_remaining = cur.free_bytes_remaining - 8'd1;
				end
				if (nxt.free_bytes_remaining == '0) begin
					nxt.reading_value = 1'b0;
					nxt.phase = PH_LEN;
				end
			end
			PH_END: begin
				role = ROLE_ERROR;
			end
			default: begin
				// Length position; stray codes start a fresh entry.
				rv_eff = (cur.phase == PH_LEN) ? cur.reading_value : 1'b0;
				nxt.reading_value = rv_eff;
				nxt.phase = PH_LEN;
				if (!rv_eff && data_byte == MAP_END) begin
					role = ROLE_END;
					nxt.phase = PH_END;
				end else if (data_byte >= LEN_BIG) begin
					nxt.bytes_remaining = '0;
					nxt.long_length_bytes_seen = '0;
					nxt.phase = PH_LONG;
				end else begin
					nxt.bytes_remaining = {{(LenW-ByteW){1'b0}}, data_byte};
					empty = (data_byte == '0);
					nxt = length_done(nxt);
				end
			end
		endcase

		state_o = nxt;
		tag.out_byte = data_byte;
		tag.role = role;
		tag.last_of_string = last;
		tag.empty_string = empty;
	end

endmodule

`default_nettype wire

/* hdl/zipmap_stream_parser.sv */
// ----------------------------------------------------------------------------
// Zipmap stream parser
// Tags every byte of a zipmap blob as framing, key, value, end or error.
// ----------------------------------------------------------------------------
// Feed the blob one byte per transaction on bytes_in, with start_of_map high
// on the first (count) byte of each blob; every byte yields exactly one tagged
// transaction on tags_out, in order. On acceptance, the parser state register
// and a short step of logic decide a byte's role, and the tag lands in a single
// output register, so a new byte is accepted every cycle as long as the output
// register is empty or being drained in the same cycle. The tag is offered in
// the cycle after acceptance. Lengths of 254, or of 255 at a value position,
// take the four-byte little-endian form; the free-count byte after a value
// length and the free bytes after the value are tagged as framing. Bytes after
// the end marker are tagged as errors until the next start mark.
// ----------------------------------------------------------------------------
`default_nettype none

module zipmap_stream_parser (
	input  wire        clk,
	input  wire        arst_n,
	zmp_in_if.sink     bytes_in,
	zmp_out_if.source  tags_out
);
	import zmp_pkg::*;

	parser_state_t state_q;
	parser_state_t state_next;
	tag_t          tag_next;
	tag_t          tag_q;
	logic          tag_valid_q;
	logic          accept;

	// Take a byte whenever the output register is free or drains this cycle.
	assign bytes_in.ready = !tag_valid_q || tags_out.ready;
	assign accept = bytes_in.valid && bytes_in.ready;

	zmp_step u_step (
		.state_i      (state_q),
		.data_byte    (bytes_in.data_byte),
		.start_of_map (bytes_in.start_of_map),
		.state_o      (state_next),
		.tag          (tag_next)
	);

	// Advance the parser only on an accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	// Output register: load on accept, drop valid once drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_valid_q <= 1'b0;
		end else if (accept) begin
			tag_valid_q <= 1'b1;
		end else if (tags_out.ready) begin
			tag_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q <= tag_next;
		end
	end

	assign tags_out.valid          = tag_valid_q;
	assign tags_out.out_byte       = tag_q.out_byte;
	assign tags_out.role           = tag_q.role;
	assign tags_out.last_of_string = tag_q.last_of_string;
	assign tags_out.empty_string   = tag_q.empty_string;

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Zipmap stream parser testbench
// Feeds zipmap blobs byte by byte and checks every tag against a byte-level
// parser kept in the bench. The blobs are mostly well formed with random
// content, mixed with truncated blobs and raw noise. Random idle gaps are
// drawn on the byte side and random stalls on the tag side.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import zmp_pkg::*;

	// Number of random bytes to queue after the directed opening.
	localparam int unsigned RANDOM_BYTES = 1300;
	// Number of cycles with no transaction on either side before the run is called hung.
	localparam int unsigned HANG_LIMIT   = 2000;
	// Number of cycles to wait after the last tag, so that a stray tag would still be seen.
	localparam int unsigned TAIL_CYCLES  = 4;

	// Directed opening, sent first, in this order.
	// - A count byte with no start mark right after reset.
	// - An empty key.
	// - An empty value with a zero free count.
	// - A one-byte key.
	// - A value length of 255, which takes the four-byte form, followed by a
	//   free byte and a value that ends in padding.
	// - A key in the 254 long form.
	// - A start mark in the middle of a blob.
	// - The end marker.
	// - Two bytes after the end.
	localparam int unsigned OPENING_N = 25;
	localparam int unsigned OPENING_RESTART = 21;
	localparam logic [8*OPENING_N-1:0] OPENING_BYTES = {
		8'h02, 8'h00, 8'h00, 8'h00,
		8'h01, 8'h41, MAP_END, 8'h02, 8'h00, 8'h00, 8'h00,
		8'h01, 8'h80, 8'h7F, 8'hAA,
		LEN_BIG, 8'h01, 8'h00, 8'h00, 8'h00, 8'h5A,
		8'h03, MAP_END, 8'h00, MAP_END
	};

	typedef struct {
		logic [ByteW-1:0] data;
		logic             start;
		int unsigned      gap;    // idle cycles before this byte is offered
		bit               drain;  // hold until every tag in flight has come back
	} feed_byte_t;

	logic clk;
	logic arst_n;

	zmp_in_if  bytes_in ();
	zmp_out_if tags_out ();

	zipmap_stream_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes_in (bytes_in),
		.tags_out (tags_out)
	);

	initial clk = 1'b0;
	always #5ns clk = ~clk;

	// ------------------------------------------------------------------------
	// Byte-level parser model: its own copy of the parser state
	// ------------------------------------------------------------------------
	phase_t           pm_phase;
	logic [LenW-1:0]  pm_str_left;   // string bytes to come, or the long length being built
	logic [2:0]       pm_long_idx;   // long-length bytes taken so far
	logic [ByteW-1:0] pm_pad_left;   // free bytes still to skip after the value
	bit               pm_in_value;   // 0: the next string is a key

	feed_byte_t       byte_q[$];     // bytes waiting to be offered
	tag_t             tag_q[$];      // tags predicted for accepted bytes, oldest first

	int unsigned n_err;
	int unsigned n_fed;
	int unsigned n_tags;
	int unsigned n_blobs;
	int unsigned n_drains;
	int unsigned role_seen [5];

	bit          tx_quiet;
	bit          drain_next;

	// The length is complete: pick what follows and flag an empty string.
	function automatic logic close_length();
		if (pm_in_value) begin
			pm_phase = PH_FREE;
		end else if (pm_str_left != '0) begin
			pm_phase = PH_STR;
		end else begin
			pm_in_value = 1'b1;
			pm_phase    = PH_LEN;
		end
		return pm_str_left == '0;
	endfunction

	// Advance the model by one byte and return the tag it must produce.
	function automatic tag_t tag_byte(input logic [ByteW-1:0] b, input logic start);
		tag_t t;
		t.out_byte       = b;
		t.role           = ROLE_FRAME;
		t.last_of_string = 1'b0;
		t.empty_string   = 1'b0;
		if (start) begin
			pm_phase    = PH_HEADER;
			pm_str_left = '0;
			pm_long_idx = '0;
			pm_pad_left = '0;
			pm_in_value = 1'b0;
		end
		case (pm_phase)
		PH_HEADER: begin
			pm_in_value = 1'b0;
			pm_phase    = PH_LEN;
		end
		PH_LONG: begin
			// Little-endian: each byte lands one octet higher.
			pm_str_left = pm_str_left | (LenW'(b) << {pm_long_idx[1:0], 3'b000});
			pm_long_idx = pm_long_idx + 3'd1;
			if (pm_long_idx >= LONG_LEN_BYTES) begin
				pm_long_idx    = '0;
				t.empty_string = close_length();
			end
		end
		PH_FREE: begin
			pm_pad_left = b;
			if (pm_str_left != '0) begin
				pm_phase = PH_STR;
			end else if (pm_pad_left != '0) begin
				pm_phase = PH_PAD;
			end else begin
				pm_in_value = 1'b0;
				pm_phase    = PH_LEN;
			end
		end
		PH_STR: begin
			t.role = pm_in_value ? ROLE_VALUE : ROLE_KEY;
			if (pm_str_left != '0) pm_str_left = pm_str_left - 1'b1;
			if (pm_str_left == '0) begin
				t.last_of_string = 1'b1;
				if (!pm_in_value) begin
					pm_in_value = 1'b1;
					pm_phase    = PH_LEN;
				end else if (pm_pad_left != '0) begin
					pm_phase = PH_PAD;
				end else begin
					pm_in_value = 1'b0;
					pm_phase    = PH_LEN;
				end
			end
		end
		PH_PAD: begin
			if (pm_pad_left != '0) pm_pad_left = pm_pad_left - 1'b1;
			if (pm_pad_left == '0) begin
				pm_in_value = 1'b0;
				pm_phase    = PH_LEN;
			end
		end
		PH_END: begin
			t.role = ROLE_ERROR;
		end
		default: begin
			// Length position; a stray phase code behaves as a key length.
			if (pm_phase != PH_LEN) begin
				pm_in_value = 1'b0;
				pm_phase    = PH_LEN;
			end
			if (!pm_in_value && b == MAP_END) begin
				t.role   = ROLE_END;
				pm_phase = PH_END;
			end else if (b >= LEN_BIG) begin
				pm_str_left = '0;
				pm_long_idx = '0;
				pm_phase    = PH_LONG;
			end else begin
				pm_str_left    = LenW'(b);
				t.empty_string = close_length();
			end
		end
		endcase
		return t;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------------

	// Queue one byte with its idle gap. Quiet stretches send back to back.
	task automatic push_byte(input logic [ByteW-1:0] b, input logic start);
		feed_byte_t f;
		f.data  = b;
		f.start = start;
		f.gap   = tx_quiet ? 0 : $urandom_range(0, 16);
		f.drain = drain_next;
		drain_next = 1'b0;
		byte_q.push_back(f);
		if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
	endtask

	// Queue one key or value: its length in short or long form, the free
	// count and the padding for a value, and random content.
	task automatic push_string(input bit is_key);
		int unsigned      len;
		int unsigned      pad;
		bit               long_form;
		logic [LenW-1:0]  len_w;
		long_form = ($urandom_range(0, 5) == 0);
		if (long_form) len = $urandom_range(0, 6);
		else if ($urandom_range(0, 19) == 0) len = $urandom_range(13, 253);
		else len = $urandom_range(0, 12);
		len_w = len;
		if (long_form) begin
			// A value may use either 254 or 255 to select the long form.
			push_byte((is_key || $urandom_range(0, 1) == 1) ? LEN_BIG : MAP_END, 1'b0);
			for (int i = 0; i < 4; i++) push_byte(len_w[8*i +: 8], 1'b0);
		end else begin
			push_byte(len_w[ByteW-1:0], 1'b0);
		end
		pad = 0;
		if (!is_key) begin
			pad = ($urandom_range(0, 31) == 0) ? $urandom_range(4, 255) : $urandom_range(0, 3);
			push_byte(ByteW'(pad), 1'b0);
		end
		repeat (len) push_byte(ByteW'($urandom), 1'b0);
		repeat (pad) push_byte(ByteW'($urandom), 1'b0);
	endtask

	// Queue a whole blob: count byte with a start mark, entries, end marker,
	// maybe a few bytes after the end. Now and then cut it short, so that the
	// next start mark lands in the middle of it.
	task automatic add_blob();
		int unsigned first;
		int unsigned cut;
		first = byte_q.size();
		push_byte(ByteW'($urandom), 1'b1);
		repeat ($urandom_range(0, 4)) begin
			push_string(1'b1);
			push_string(1'b0);
		end
		push_byte(MAP_END, 1'b0);
		repeat ($urandom_range(0, 2)) push_byte(ByteW'($urandom), 1'b0);
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(first + 1, byte_q.size() - 1);
			while (byte_q.size() > cut) void'(byte_q.pop_back());
		end
		n_blobs++;
	endtask

	// Queue a burst of raw bytes with stray start marks.
	task automatic add_noise();
		repeat ($urandom_range(1, 20)) push_byte(ByteW'($urandom), $urandom_range(0, 7) == 0);
	endtask

	// ------------------------------------------------------------------------
	// Byte driver: offer queued bytes, predict a tag for each transaction
	// ------------------------------------------------------------------------
	int unsigned tx_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_in.valid        <= 1'b0;
			bytes_in.data_byte    <= '0;
			bytes_in.start_of_map <= 1'b0;
			tx_wait               <= 0;
		end else begin
			if (bytes_in.valid && bytes_in.ready) begin
				tag_q.push_back(tag_byte(bytes_in.data_byte, bytes_in.start_of_map));
				n_fed++;
			end
			// Load the next byte only once the current one is gone.
			if (!bytes_in.valid || bytes_in.ready) begin
				if (byte_q.size() == 0) begin
					bytes_in.valid <= 1'b0;
				end else if (tx_wait < byte_q[0].gap ||
						(byte_q[0].drain && tag_q.size() != 0)) begin
					// Idle through the gap, or hold until every tag is back.
					bytes_in.valid <= 1'b0;
					tx_wait        <= tx_wait + 1;
				end else begin
					if (byte_q[0].drain) n_drains++;
					bytes_in.valid        <= 1'b1;
					bytes_in.data_byte    <= byte_q[0].data;
					bytes_in.start_of_map <= byte_q[0].start;
					tx_wait               <= 0;
					void'(byte_q.pop_front());
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tag monitor: stall at random, check each tag against the oldest prediction
	// ------------------------------------------------------------------------
	int unsigned rx_stall;
	int unsigned rx_draw;
	bit          rx_quiet;
	tag_t        got_tag;
	tag_t        want_tag;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tags_out.ready <= 1'b0;
			rx_stall       <= 0;
			rx_quiet       <= 1'b0;
		end else if (tags_out.valid && tags_out.ready) begin
			got_tag.out_byte       = tags_out.out_byte;
			got_tag.role           = tags_out.role;
			got_tag.last_of_string = tags_out.last_of_string;
			got_tag.empty_string   = tags_out.empty_string;
			n_tags++;
			if (!$isunknown(tags_out.role) && tags_out.role <= ROLE_ERROR)
				role_seen[tags_out.role]++;
			if (tag_q.size() == 0) begin
				n_err++;
				$display("%0t: unexpected tag, expected none, %s",
					$time, $sformatf("got byte=%02h role=%0d last=%b empty=%b",
					got_tag.out_byte, got_tag.role,
					got_tag.last_of_string, got_tag.empty_string));
			end else begin
				want_tag = tag_q.pop_front();
				if (got_tag !== want_tag) begin
					n_err++;
					$display("%0t: tag mismatch, %s, %s", $time,
						$sformatf("expected byte=%02h role=%0d last=%b empty=%b",
						want_tag.out_byte, want_tag.role,
						want_tag.last_of_string, want_tag.empty_string),
						$sformatf("got byte=%02h role=%0d last=%b empty=%b",
						got_tag.out_byte, got_tag.role,
						got_tag.last_of_string, got_tag.empty_string));
				end
			end
			// Draw the stall that follows this transaction.
			if ($urandom_range(0, 47) == 0) rx_quiet <= !rx_quiet;
			rx_draw = rx_quiet ? 0 : $urandom_range(0, 16);
			if (rx_draw == 0) begin
				tags_out.ready <= 1'b1;
			end else begin
				tags_out.ready <= 1'b0;
				rx_stall       <= rx_draw;
			end
		end else if (!tags_out.ready) begin
			if (rx_stall <= 1) begin
				tags_out.ready <= 1'b1;
				rx_stall       <= 0;
			end else begin
				rx_stall <= rx_stall - 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Hang watchdog: count cycles with no transaction on either side
	// ------------------------------------------------------------------------
	int unsigned idle_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((bytes_in.valid && bytes_in.ready) || (tags_out.valid && tags_out.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d tags still expected",
				HANG_LIMIT, tag_q.size());
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		bytes_in.valid        = 1'b0;
		bytes_in.data_byte    = '0;
		bytes_in.start_of_map = 1'b0;
		tags_out.ready        = 1'b0;
		arst_n                = 1'b0;

		pm_phase    = PH_HEADER;
		pm_str_left = '0;
		pm_long_idx = '0;
		pm_pad_left = '0;
		pm_in_value = 1'b0;
		n_err       = 0;
		n_fed       = 0;
		n_tags      = 0;
		n_blobs     = 0;
		n_drains    = 0;
		role_seen   = '{default: 0};
		tx_quiet    = 1'b0;
		drain_next  = 1'b0;

		// Directed opening, gaps drawn as usual.
		for (int i = 0; i < OPENING_N; i++)
			push_byte(OPENING_BYTES[8*(OPENING_N-1-i) +: 8], i == OPENING_RESTART);

		// Random part: mostly well-formed blobs, some noise. The first random
		// byte waits for the opening to drain, and so do a few later ones.
		drain_next = 1'b1;
		while (byte_q.size() < OPENING_N + RANDOM_BYTES) begin
			if ($urandom_range(0, 19) == 0) drain_next = 1'b1;
			if ($urandom_range(0, 9) == 0) add_noise();
			else add_blob();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Sample on the falling edge, clear of the drivers' updates.
		@(negedge clk);
		while (byte_q.size() != 0 || bytes_in.valid || tag_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d blobs plus noise bursts: %0d bytes fed, %0d tags checked, %0d drain pauses.",
			n_blobs, n_fed, n_tags, n_drains);
		$display("Tags by role: framing %0d, key %0d, value %0d, end %0d, error %0d.",
			role_seen[ROLE_FRAME], role_seen[ROLE_KEY], role_seen[ROLE_VALUE],
			role_seen[ROLE_END], role_seen[ROLE_ERROR]);
		if (n_err == 0 && tag_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d tag errors, %0d tags never came", n_err, tag_q.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/zmp_pkg.sv
hdl/zmp_if.sv
hdl/zmp_step.sv
hdl/zipmap_stream_parser.sv
bench/tb.sv
